[rtl/ramped_straight_drive_profile_defines.svh]
// Assertion macros shared by the checker of the straight-drive profile block
`ifndef RAMPED_STRAIGHT_DRIVE_PROFILE_DEFINES_SVH
`define RAMPED_STRAIGHT_DRIVE_PROFILE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define RSDP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define RSDP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/rsdp_pkg.sv]
// Types, constants and width helpers of the straight-drive profile block
package rsdp_pkg;

  // Field widths
  localparam int TargetW = 21;
  localparam int SpeedW  = 9;
  localparam int AccelW  = 7;
  localparam int SlowW   = 16;
  localparam int GainW   = 5;
  localparam int DeltaW  = 12;
  localparam int HeadW   = 32;
  localparam int HeadHiW = 16;
  localparam int DriveW  = 10;
  localparam int CurW    = 10;
  localparam int DegW    = 9;
  localparam int HProdW  = 25;
  localparam int GdW     = 15;

  // Degrees per full turn
  localparam int DegScale = 360;

  // Configuration port
  localparam int AddrW = 5;
  localparam int DataW = 32;

  localparam logic [2:0] REG_TARGET_COUNT  = 3'd0;
  localparam logic [2:0] REG_TOP_SPEED     = 3'd1;
  localparam logic [2:0] REG_MIN_SPEED     = 3'd2;
  localparam logic [2:0] REG_ACCEL_STEP    = 3'd3;
  localparam logic [2:0] REG_SLOW_DISTANCE = 3'd4;
  localparam logic [2:0] REG_HEADING_GAIN  = 3'd5;

  localparam logic [TargetW-1:0] RST_TARGET_COUNT  = 21'd5000;
  localparam logic [SpeedW-1:0]  RST_TOP_SPEED     = 9'd400;
  localparam logic [SpeedW-1:0]  RST_MIN_SPEED     = 9'd140;
  localparam logic [AccelW-1:0]  RST_ACCEL_STEP    = 7'd2;
  localparam logic [SlowW-1:0]   RST_SLOW_DISTANCE = 16'd1400;
  localparam logic [GainW-1:0]   RST_HEADING_GAIN  = 5'd5;

  // Operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef struct packed {
    logic [TargetW-1:0] target_count;
    logic [SpeedW-1:0]  top_speed;
    logic [SpeedW-1:0]  min_speed;
    logic [AccelW-1:0]  accel_step;
    logic [SlowW-1:0]   slow_distance;
    logic [GainW-1:0]   heading_gain;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic calc;
    logic mul;
    logic div_step;
    logic write;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic tick_run;
    logic out_free;
  } dp_status_t;

  // Signed width that holds target minus travelled count
  function automatic int dist_bits(int cb);
    return ((cb > 22) ? cb : 22) + 2;
  endfunction

  // Width of the deceleration product, also the divider step count
  function automatic int prod_bits(int cb);
    return dist_bits(cb) + SpeedW;
  endfunction

endpackage

[rtl/rsdp_regs.sv]
// Configuration register file with APB-style access
module rsdp_regs import rsdp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t       cfg_q;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[AddrW-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_count  <= RST_TARGET_COUNT;
      cfg_q.top_speed     <= RST_TOP_SPEED;
      cfg_q.min_speed     <= RST_MIN_SPEED;
      cfg_q.accel_step    <= RST_ACCEL_STEP;
      cfg_q.slow_distance <= RST_SLOW_DISTANCE;
      cfg_q.heading_gain  <= RST_HEADING_GAIN;
    end else if (wr_en) begin
      case (reg_idx)
        REG_TARGET_COUNT:  cfg_q.target_count  <= pwdata[TargetW-1:0];
        REG_TOP_SPEED:     cfg_q.top_speed     <= pwdata[SpeedW-1:0];
        REG_MIN_SPEED:     cfg_q.min_speed     <= pwdata[SpeedW-1:0];
        REG_ACCEL_STEP:    cfg_q.accel_step    <= pwdata[AccelW-1:0];
        REG_SLOW_DISTANCE: cfg_q.slow_distance <= pwdata[SlowW-1:0];
        REG_HEADING_GAIN:  cfg_q.heading_gain  <= pwdata[GainW-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_TARGET_COUNT:  prdata = DataW'(cfg_q.target_count);
      REG_TOP_SPEED:     prdata = DataW'(cfg_q.top_speed);
      REG_MIN_SPEED:     prdata = DataW'(cfg_q.min_speed);
      REG_ACCEL_STEP:    prdata = DataW'(cfg_q.accel_step);
      REG_SLOW_DISTANCE: prdata = DataW'(cfg_q.slow_distance);
      REG_HEADING_GAIN:  prdata = DataW'(cfg_q.heading_gain);
      default:           prdata = '0;
    endcase
  end

endmodule

[rtl/rsdp_ctrl.sv]
// Straight-drive sequencer: capture, calc, multiply, divide (active ticks), write
module rsdp_ctrl import rsdp_pkg::*; #(
  parameter int COUNT_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  localparam int ProdW = prod_bits(COUNT_BITS);
  localparam int StepW = $clog2(ProdW);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CALC  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [StepW-1:0] cnt_q, cnt_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = status_i.tick_run ? S_CALC : S_WRITE;
        end
      end
      S_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        cnt_d     = StepW'(ProdW - 1);
        state_d   = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = S_WRITE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_WRITE: begin
        if (status_i.out_free) begin
          cmd_o.write = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

[rtl/rsdp_datapath.sv]
// Datapath: run state, heading scale, ramp multiply, restoring divider, output register
module rsdp_datapath import rsdp_pkg::*; #(
  parameter int COUNT_BITS = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cfg_t                     cfg_i,
  input  dp_cmd_t                  cmd_i,
  output dp_status_t               status_o,
  input  logic                     operation_i,
  input  logic signed [DeltaW-1:0] left_count_delta_i,
  input  logic signed [HeadW-1:0]  heading_raw_i,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic signed [DriveW-1:0] left_drive_o,
  output logic signed [DriveW-1:0] right_drive_o,
  output logic                     done_res_o
);

  localparam int DistW  = dist_bits(COUNT_BITS);
  localparam int ProdW  = prod_bits(COUNT_BITS);
  localparam int NsW    = ProdW + 2;
  localparam int SpdW   = SpeedW + 3;
  localparam int CurMin = -(2 ** (CurW - 1));

  // Saturate a drive sum to plus or minus the top speed
  function automatic logic [DriveW-1:0] sat_drive(logic signed [GdW-1:0] v,
                                                  logic [SpeedW-1:0] top);
    logic signed [GdW-1:0] hi;
    logic signed [GdW-1:0] lo;
    hi = $signed({{(GdW-SpeedW){1'b0}}, top});
    lo = -hi;
    if (v > hi) begin
      return hi[DriveW-1:0];
    end else if (v < lo) begin
      return lo[DriveW-1:0];
    end
    return v[DriveW-1:0];
  endfunction

  // Run state
  logic signed [COUNT_BITS-1:0] travelled_q;
  logic signed [CurW-1:0]       cur_q;
  logic                         running_q;

  // Captured item
  logic                      op_q;
  logic signed [DeltaW-1:0]  delta_q;
  logic signed [HeadHiW-1:0] head_q;

  // Work registers
  logic signed [COUNT_BITS-1:0] trav_q;
  logic signed [DistW-1:0]      dist_q;
  logic signed [DegW-1:0]       deg_q;
  logic signed [GdW-1:0]        gd_q;
  logic                         neg_q;
  logic [ProdW-1:0]             quo_q;
  logic [SlowW-1:0]             rem_q;

  // Output register
  logic                     out_valid_q;
  logic signed [DriveW-1:0] left_q, right_q;
  logic                     done_q;

  assign status_o.tick_run = (operation_i == OP_TICK) && running_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  // Travelled count, remaining distance and heading in degrees
  logic signed [COUNT_BITS-1:0] trav_sum;
  logic signed [DistW-1:0]      dist_calc;
  logic signed [HProdW-1:0]     hprod;

  assign trav_sum  = travelled_q + {{(COUNT_BITS-DeltaW){delta_q[DeltaW-1]}}, delta_q};
  assign dist_calc = $signed({{(DistW-TargetW){1'b0}}, cfg_i.target_count})
                   - $signed({{(DistW-COUNT_BITS){trav_sum[COUNT_BITS-1]}}, trav_sum});
  assign hprod     = $signed({{(HProdW-HeadHiW){head_q[HeadHiW-1]}}, head_q})
                   * $signed(HProdW'(DegScale));

  // Ramp product magnitude and heading term
  logic [DistW-1:0]         span;
  logic signed [SpeedW:0]   spread, spread_neg;
  logic [SpeedW-1:0]        spread_mag;
  logic [ProdW-1:0]         prod;
  logic signed [GdW-1:0]    gd_calc;

  assign span       = DistW'(cfg_i.slow_distance) - dist_q;
  assign spread     = $signed({1'b0, cfg_i.top_speed}) - $signed({1'b0, cfg_i.min_speed});
  assign spread_neg = -spread;
  assign spread_mag = spread[SpeedW] ? spread_neg[SpeedW-1:0] : spread[SpeedW-1:0];
  assign prod       = span * spread_mag;
  assign gd_calc    = $signed({1'b0, cfg_i.heading_gain}) * deg_q;

  // One restoring divide step per cycle
  logic [SlowW:0] rem_shift, rem_sub;
  logic           rem_ge;

  assign rem_shift = {rem_q, quo_q[ProdW-1]};
  assign rem_ge    = rem_shift >= {1'b0, cfg_i.slow_distance};
  assign rem_sub   = rem_shift - {1'b0, cfg_i.slow_distance};

  // Ceiling of the deduction and the decelerated speed
  logic signed [NsW-1:0] quo_ext, ceil_v, ns, cur_wide;
  logic                  slow_zero;

  assign slow_zero = (cfg_i.slow_distance == '0);
  assign quo_ext   = $signed({2'b00, quo_q});
  assign ceil_v    = neg_q ? -quo_ext : quo_ext + NsW'(rem_q != '0);
  assign ns        = slow_zero ? $signed({{(NsW-SpeedW){1'b0}}, cfg_i.min_speed})
                   : $signed({{(NsW-SpeedW){1'b0}}, cfg_i.top_speed}) - ceil_v;
  assign cur_wide  = $signed({{(NsW-CurW){cur_q[CurW-1]}}, cur_q});

  // Speed update
  logic signed [SpdW-1:0] cur_s, top_s, mn_s, sum_s;
  logic                   far;
  logic signed [CurW-1:0] cur_new;

  assign cur_s = $signed({{(SpdW-CurW){cur_q[CurW-1]}}, cur_q});
  assign top_s = $signed({{(SpdW-SpeedW){1'b0}}, cfg_i.top_speed});
  assign mn_s  = $signed({{(SpdW-SpeedW){1'b0}}, cfg_i.min_speed});
  assign sum_s = cur_s + $signed({{(SpdW-AccelW){1'b0}}, cfg_i.accel_step});
  assign far   = !(dist_q < $signed({{(DistW-SlowW){1'b0}}, cfg_i.slow_distance}));

  always_comb begin
    cur_new = cur_q;
    if ((cur_s < top_s) && far) begin
      cur_new = (sum_s > top_s) ? top_s[CurW-1:0] : sum_s[CurW-1:0];
    end else if (cur_s < mn_s) begin
      cur_new = (sum_s > mn_s) ? mn_s[CurW-1:0] : sum_s[CurW-1:0];
    end else if (!far) begin
      if (ns < cur_wide) begin
        cur_new = (ns < NsW'(CurMin)) ? CurW'(CurMin) : ns[CurW-1:0];
      end
    end
  end

  // Wheel drives and finish flag
  logic signed [GdW-1:0]    cur_g, left_sum, right_sum;
  logic [DriveW-1:0]        left_sat, right_sat;
  logic                     done_hit;

  assign cur_g     = $signed({{(GdW-CurW){cur_new[CurW-1]}}, cur_new});
  assign left_sum  = cur_g + gd_q;
  assign right_sum = cur_g - gd_q;
  assign left_sat  = sat_drive(left_sum, cfg_i.top_speed);
  assign right_sat = sat_drive(right_sum, cfg_i.top_speed);
  assign done_hit  = dist_q[DistW-1] || (dist_q == '0);

  // Capture and work registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= operation_i;
      delta_q <= left_count_delta_i;
      head_q  <= heading_raw_i[HeadW-1 -: HeadHiW];
    end
    if (cmd_i.calc) begin
      trav_q <= trav_sum;
      dist_q <= dist_calc;
      deg_q  <= hprod[HProdW-1 -: DegW];
    end
    if (cmd_i.mul) begin
      quo_q <= prod;
      rem_q <= '0;
      neg_q <= spread[SpeedW];
      gd_q  <= gd_calc;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[ProdW-2:0], rem_ge};
      rem_q <= rem_ge ? rem_sub[SlowW-1:0] : rem_shift[SlowW-1:0];
    end
  end

  // Run state updates on result write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      travelled_q <= '0;
      cur_q       <= '0;
      running_q   <= 1'b0;
    end else if (cmd_i.write) begin
      if (op_q == OP_START) begin
        travelled_q <= '0;
        cur_q       <= $signed({{(CurW-AccelW){1'b0}}, cfg_i.accel_step});
        running_q   <= (cfg_i.target_count != '0);
      end else if (running_q) begin
        travelled_q <= trav_q;
        cur_q       <= cur_new;
        running_q   <= !done_hit;
      end
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      if (op_q == OP_START) begin
        left_q  <= '0;
        right_q <= '0;
        done_q  <= (cfg_i.target_count == '0);
      end else if (running_q) begin
        left_q  <= left_sat;
        right_q <= right_sat;
        done_q  <= done_hit;
      end else begin
        left_q  <= '0;
        right_q <= '0;
        done_q  <= 1'b1;
      end
    end
  end

  // Output valid: set on write, cleared on transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.write) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign left_drive_o  = left_q;
  assign right_drive_o = right_q;
  assign done_res_o    = done_q;

endmodule

[rtl/ramped_straight_drive_profile.sv]
// Top level of the ramped straight-drive profile with heading correction
//
//   channel  handshake              payload
//   ------   ---------------------  ------------------------------------------
//   cfg      psel/penable/pwrite    paddr, pwdata, prdata (pready tied high)
//   in       in_valid_i/in_ready_o  operation_i, left_count_delta_i, heading_raw_i
//   out      out_valid_o/out_ready_i left_drive_o, right_drive_o, done_res_o
//
// A control tick of an active run passes from input transfer through the states CALC, MUL,
// DIV and WRITE to its result; the divider in DIV yields one quotient bit per cycle.
// A start item or a tick with no active run goes straight from IDLE to WRITE.
// One item is in work at a time; the next input transfer is taken once the result
// sits in the output register, even while that result waits for out_ready_i.
// Reset loads the register defaults and leaves no run active.
module ramped_straight_drive_profile import rsdp_pkg::*; #(
  parameter int COUNT_BITS = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [AddrW-1:0]         paddr,
  input  logic [DataW-1:0]         pwdata,
  output logic [DataW-1:0]         prdata,
  output logic                     pready,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     operation_i,
  input  logic signed [DeltaW-1:0] left_count_delta_i,
  input  logic signed [HeadW-1:0]  heading_raw_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DriveW-1:0] left_drive_o,
  output logic signed [DriveW-1:0] right_drive_o,
  output logic                     done_res_o
);

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  // Configuration registers
  rsdp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sequencer
  rsdp_ctrl #(
    .COUNT_BITS (COUNT_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath
  rsdp_datapath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg),
    .cmd_i              (cmd),
    .status_o           (status),
    .operation_i        (operation_i),
    .left_count_delta_i (left_count_delta_i),
    .heading_raw_i      (heading_raw_i),
    .out_ready_i        (out_ready_i),
    .out_valid_o        (out_valid_o),
    .left_drive_o       (left_drive_o),
    .right_drive_o      (right_drive_o),
    .done_res_o         (done_res_o)
  );

endmodule

[rtl/rsdp_checker.sv]
// Port-level checker of the straight-drive profile, bound to the top level
`include "ramped_straight_drive_profile_defines.svh"

module rsdp_checker import rsdp_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic signed [DriveW-1:0] left_drive_o,
  input logic signed [DriveW-1:0] right_drive_o,
  input logic                     done_res_o
);

  // Stalled result holds
  `RSDP_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(left_drive_o) && $stable(right_drive_o) && $stable(done_res_o), "stalled result changed")

  // One item at a time: busy right after an input transfer
  `RSDP_ASSERT_NEXT(a_busy_after_in, in_valid_i && in_ready_o, !in_ready_o, "input taken while busy")

  // A new result never appears in the cycle right after an input transfer
  `RSDP_ASSERT_SAME(a_no_early_out, $rose(out_valid_o), !$past(in_valid_i && in_ready_o), "result too early")

  // A valid result never has a drive at the most negative code
  `RSDP_ASSERT_SAME(a_drive_range, out_valid_o, (left_drive_o != -10'sd512) && (right_drive_o != -10'sd512), "drive out of range")

endmodule

bind ramped_straight_drive_profile rsdp_checker u_rsdp_checker (.*);
